/* rtl/ffpa_pkg.sv */
`timescale 1ns / 1ps
package ffpa_pkg;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] start_page;
    logic [16:0] page_count;
  } ffpa_in_t;

  typedef struct packed {
    logic        granted;
    logic [15:0] alloc_start;
    logic [16:0] free_total;
    logic [1:0]  error_code;
  } ffpa_out_t;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_SHORT = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;
  localparam logic [1:0] ERR_ZERO  = 2'd3;

  localparam logic [16:0] SAT17 = 17'h1FFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ARD,
    ST_ACMP,
    ST_FRD,
    ST_FCMP,
    ST_FDONE,
    ST_PRD,
    ST_PCMP,
    ST_SHIFT,
    ST_WRITE,
    ST_RESP
  } ffpa_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic rd_issue;
    logic scan_miss;
    logic alloc_cmp;
    logic free_cmp;
    logic free_done;
    logic pos_cmp;
    logic shift_step;
    logic write_final;
    logic respond;
  } ffpa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic early_done;
    logic is_alloc;
    logic is_add;
    logic scan_end;
    logic alloc_hit;
    logic free_fail;
    logic pos_hit;
    logic shift_end;
    logic shrink_only;
  } ffpa_stat_t;

endpackage

/* rtl/ffpa_ctrl.sv */
`timescale 1ns / 1ps
module ffpa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ffpa_pkg::ffpa_stat_t stat,
  output ffpa_pkg::ffpa_cmd_t  cmd
);
  import ffpa_pkg::*;

  ffpa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (stat.early_done)    state_nxt = ST_RESP;
        else if (stat.is_alloc) state_nxt = ST_ARD;
        else if (stat.is_add)   state_nxt = ST_WRITE;
        else                    state_nxt = ST_FRD;
      end
      ST_ARD:   state_nxt = stat.scan_end ? ST_RESP : ST_ACMP;
      ST_ACMP: begin
        if (stat.alloc_hit)
          state_nxt = stat.shrink_only ? ST_RESP : ST_SHIFT;
        else
          state_nxt = ST_ARD;
      end
      ST_FRD:   state_nxt = stat.scan_end ? ST_FDONE : ST_FCMP;
      ST_FCMP:  state_nxt = ST_FRD;
      ST_FDONE: state_nxt = stat.free_fail ? ST_RESP : ST_PRD;
      ST_PRD:   state_nxt = stat.scan_end ? ST_WRITE : ST_PCMP;
      ST_PCMP:  state_nxt = stat.pos_hit ? ST_SHIFT : ST_PRD;
      ST_SHIFT: state_nxt = stat.shift_end ? ST_WRITE : ST_SHIFT;
      ST_WRITE: state_nxt = ST_RESP;
      ST_RESP:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE:  cmd.load        = start;
      ST_CHECK: cmd.rd_issue    = 1'b1;
      ST_ARD:   cmd.scan_miss   = stat.scan_end;
      ST_ACMP:  cmd.alloc_cmp   = 1'b1;
      ST_FRD:   cmd             = '0;
      ST_FCMP:  cmd.free_cmp    = 1'b1;
      ST_FDONE: cmd.free_done   = 1'b1;
      ST_PRD:   cmd             = '0;
      ST_PCMP:  cmd.pos_cmp     = 1'b1;
      ST_SHIFT: cmd.shift_step  = 1'b1;
      ST_WRITE: cmd.write_final = 1'b1;
      ST_RESP:  cmd.respond     = 1'b1;
      default:  cmd             = '0;
    endcase
  end

endmodule

/* rtl/ffpa_dp.sv */
`timescale 1ns / 1ps
module ffpa_dp #(
  parameter int NUM_PAGES   = 65536,
  parameter int MAX_EXTENTS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ffpa_pkg::ffpa_in_t   in_item,
  input  ffpa_pkg::ffpa_cmd_t  cmd,
  output ffpa_pkg::ffpa_stat_t stat,
  output logic                 out_valid,
  output ffpa_pkg::ffpa_out_t  out_item
);
  import ffpa_pkg::*;

  localparam int AW = $clog2(MAX_EXTENTS);
  localparam int CW = AW + 1;
  localparam int PW = $clog2(NUM_PAGES) + 1;
  localparam int XW = (PW > 17) ? PW : 17;
  localparam logic [CW-1:0] MAXC = CW'(MAX_EXTENTS);
  localparam logic [PW-1:0] NP   = PW'(NUM_PAGES);

  // table memory: {start, length}
  logic [32:0] mem [MAX_EXTENTS];
  logic [32:0] rd_data_r;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [32:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data_r <= mem[raddr];
  end

  logic [CW-1:0] count_r, count_nxt;
  logic [16:0]   free_r, free_nxt;
  logic [1:0]    op_r;
  logic [15:0]   s_r;
  logic [16:0]   n_r;
  logic [CW-1:0] idx_r, idx_nxt;   // read/scan index
  logic [CW-1:0] w_r, w_nxt;       // compaction write index
  logic [CW-1:0] pos_r, pos_nxt;   // insert position
  logic          any_r, any_nxt;
  logic [16:0]   bs_r, bs_nxt;     // merged block start (17b for end compare)
  logic [16:0]   bl_r, bl_nxt;
  logic [15:0]   where_r, where_nxt;
  logic [1:0]    err_r, err_nxt;
  logic          out_valid_nxt;
  ffpa_out_t     out_nxt;

  // clip count for add/free
  logic [16:0] clip_n;
  logic [PW-1:0] lim;
  always_comb begin
    lim = NP - PW'(in_item.start_page);
    if (XW'(in_item.start_page) >= XW'(NP)) clip_n = '0;
    else if (XW'(in_item.page_count) > XW'(lim))
      clip_n = 17'(lim);
    else clip_n = in_item.page_count;
  end

  logic [15:0] e_s;
  logic [16:0] e_l;
  logic [17:0] bend, pend;
  logic [17:0] sum1, sum2;
  assign e_s  = rd_data_r[32:17];
  assign e_l  = rd_data_r[16:0];
  assign bend = 18'(bs_r) + 18'(bl_r);
  assign pend = 18'(e_s) + 18'(e_l);
  assign sum1 = 18'(bl_r) + 18'(e_l);
  assign sum2 = 18'(free_r) + 18'(n_r);

  logic merge_hi, merge_lo;
  assign merge_hi = (bend == 18'(e_s));
  assign merge_lo = !merge_hi && (pend == 18'(bs_r));

  always_comb begin
    stat = '0;
    stat.is_alloc    = (op_r == OP_ALLOC);
    stat.is_add      = (op_r == OP_ADD);
    stat.early_done  = (op_r != OP_ADD && op_r != OP_ALLOC && op_r != OP_FREE)
                     || (n_r == '0)
                     || (op_r == OP_ALLOC && n_r > free_r)
                     || (op_r == OP_ADD && count_r >= MAXC);
    stat.scan_end    = (idx_r >= count_r);
    stat.alloc_hit   = (e_l >= n_r);
    stat.shrink_only = (e_l > n_r);
    stat.free_fail   = !any_r && (count_r >= MAXC);
    stat.pos_hit     = (bend <= 18'(e_s));
    stat.shift_end   = (idx_r == pos_r + CW'(1));
  end

  always_comb begin
    count_nxt = count_r;  free_nxt = free_r;
    idx_nxt = idx_r;  w_nxt = w_r;  pos_nxt = pos_r;
    any_nxt = any_r;  bs_nxt = bs_r;  bl_nxt = bl_r;
    where_nxt = where_r;  err_nxt = err_r;
    we = 1'b0;  waddr = '0;  wdata = '0;
    raddr = idx_r[AW-1:0];
    out_valid_nxt = 1'b0;
    out_nxt = out_item;

    if (cmd.load) begin
      err_nxt = ERR_OK;  where_nxt = '0;
      idx_nxt = '0;  w_nxt = '0;  pos_nxt = '0;
      any_nxt = 1'b0;
      bs_nxt = {1'b0, in_item.start_page};
      bl_nxt = (in_item.op == OP_ALLOC) ? in_item.page_count : clip_n;
      raddr = '0;
    end

    if (cmd.rd_issue) begin
      // check stage: bad opcode, zero count, short total, full table on add
      if (op_r != OP_ADD && op_r != OP_ALLOC && op_r != OP_FREE) err_nxt = ERR_ZERO;
      else if (n_r == '0) err_nxt = ERR_ZERO;
      else if (op_r == OP_ALLOC && n_r > free_r) err_nxt = ERR_SHORT;
      else if (op_r == OP_ADD && count_r >= MAXC) err_nxt = ERR_FULL;
      raddr = idx_r[AW-1:0];
    end

    // no extent long enough
    if (cmd.scan_miss) err_nxt = ERR_SHORT;

    if (cmd.alloc_cmp) begin
      if (stat.alloc_hit) begin
        where_nxt = e_s;
        free_nxt = free_r - n_r;
        if (stat.shrink_only) begin
          we = 1'b1;  waddr = idx_r[AW-1:0];
          wdata = {16'(e_s + n_r[15:0]), 17'(e_l - n_r)};
        end else begin
          // remove: shift entries down from idx+1
          count_nxt = count_r - CW'(1);
          w_nxt = idx_r;
          pos_nxt = count_r - CW'(1);
          idx_nxt = idx_r + CW'(1);
          raddr = AW'(idx_r + CW'(1));
        end
      end else begin
        idx_nxt = idx_r + CW'(1);
        raddr = AW'(idx_r + CW'(1));
      end
    end

    if (cmd.free_cmp) begin
      if (merge_hi) begin
        bl_nxt = (sum1 > 18'(SAT17)) ? SAT17 : sum1[16:0];
        any_nxt = 1'b1;
      end else if (merge_lo) begin
        bl_nxt = (sum1 > 18'(SAT17)) ? SAT17 : sum1[16:0];
        bs_nxt = {1'b0, e_s};
        any_nxt = 1'b1;
      end else begin
        // keep: compact in place
        we = 1'b1;  waddr = w_r[AW-1:0];  wdata = rd_data_r;
        w_nxt = w_r + CW'(1);
      end
      idx_nxt = idx_r + CW'(1);
      raddr = AW'(idx_r + CW'(1));
    end

    if (cmd.free_done) begin
      if (stat.free_fail) err_nxt = ERR_FULL;
      else begin
        // second pass over the compacted table finds the insert slot
        count_nxt = w_r;
        pos_nxt = w_r;
        idx_nxt = '0;
        raddr = '0;
      end
    end

    if (cmd.pos_cmp) begin
      if (stat.pos_hit) begin
        pos_nxt = idx_r;
        w_nxt = count_r;
        idx_nxt = count_r;
        raddr = AW'(count_r - CW'(1));
      end else begin
        idx_nxt = idx_r + CW'(1);
        raddr = AW'(idx_r + CW'(1));
      end
    end

    if (cmd.shift_step) begin
      // read is one behind: idx_r addresses source, rd_data_r holds previous
      // alloc remove: mem[w] <= mem[w+1]; free insert: mem[i] <= mem[i-1]
      if (op_r == OP_ALLOC) begin
        // pos_r = new count; copy upward source to w
        we = (w_r != pos_r);
        waddr = w_r[AW-1:0];  wdata = rd_data_r;
        w_nxt = w_r + CW'(1);
        idx_nxt = idx_r + CW'(1);
        raddr = AW'(idx_r + CW'(1));
      end else begin
        we = 1'b1;  waddr = AW'(w_r);  wdata = rd_data_r;
        w_nxt = w_r - CW'(1);
        idx_nxt = idx_r - CW'(1);
        raddr = AW'(idx_r - CW'(2));
      end
    end

    if (cmd.write_final) begin
      if (op_r == OP_FREE) begin
        we = 1'b1;  waddr = pos_r[AW-1:0];  wdata = {bs_r[15:0], bl_r};
        count_nxt = count_r + CW'(1);
        free_nxt = (sum2 > 18'(SAT17)) ? SAT17 : sum2[16:0];
      end else if (op_r == OP_ADD) begin
        we = 1'b1;  waddr = count_r[AW-1:0];  wdata = {s_r, n_r};
        count_nxt = count_r + CW'(1);
        free_nxt = (sum2 > 18'(SAT17)) ? SAT17 : sum2[16:0];
      end
    end

    if (cmd.respond) begin
      out_valid_nxt = 1'b1;
      out_nxt.granted     = (err_r == ERR_OK);
      out_nxt.alloc_start = (err_r == ERR_OK) ? where_r : '0;
      out_nxt.free_total  = free_r;
      out_nxt.error_code  = err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;  free_r <= '0;  out_valid <= 1'b0;
    end else begin
      count_r <= count_nxt;  free_r <= free_nxt;  out_valid <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_item.op;  s_r <= in_item.start_page;
      n_r  <= (in_item.op == OP_ALLOC) ? in_item.page_count : clip_n;
    end
    idx_r <= idx_nxt;  w_r <= w_nxt;  pos_r <= pos_nxt;
    any_r <= any_nxt;
    bs_r <= bs_nxt;  bl_r <= bl_nxt;  where_r <= where_nxt;  err_r <= err_nxt;
    out_item <= out_nxt;
  end

endmodule

/* rtl/first_fit_page_allocator.sv */
`timescale 1ns / 1ps
// channel  ports                         direction  transaction
// input    start, busy, in_item          in         start && !busy
// result   out_valid, out_item           out        out_valid, one cycle
//
// busy: CHECK, RESP when refused at the check; CHECK, WRITE, RESP for an add.
// allocate: ARD and ACMP per extent scanned, SHIFT per entry moved down on removal.
// free: FRD and FCMP per extent to merge, FDONE, PRD and PCMP per extent passed,
// SHIFT per entry moved up, then WRITE and RESP; the strobe rises as busy falls.
// reset (rst_n low, synchronous) empties the table and zeroes the total.
// the receiver cannot stall; busy holds off new starts until the result.
module first_fit_page_allocator #(
  parameter int NUM_PAGES   = 65536,
  parameter int MAX_EXTENTS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ffpa_pkg::ffpa_in_t  in_item,
  output logic               out_valid,
  output ffpa_pkg::ffpa_out_t out_item
);
  import ffpa_pkg::*;

  ffpa_cmd_t  cmd;
  ffpa_stat_t stat;

  ffpa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .stat(stat), .cmd(cmd)
  );

  ffpa_dp #(.NUM_PAGES(NUM_PAGES), .MAX_EXTENTS(MAX_EXTENTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .cmd(cmd), .stat(stat),
    .out_valid(out_valid), .out_item(out_item)
  );

endmodule

/* sim/first_fit_page_allocator_test.sv */
`timescale 1ns / 1ps
module first_fit_page_allocator_test;
  import ffpa_pkg::*;

  localparam int unsigned PAGE_SPAN   = 65536;
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned LEN_SAT     = 131071;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  ffpa_in_t  in_item;
  logic      out_valid;
  ffpa_out_t out_item;

  first_fit_page_allocator uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // shadow of the free extent table
  int unsigned ext_base [TABLE_DEPTH];
  int unsigned ext_len  [TABLE_DEPTH];
  int unsigned ext_cnt;
  int unsigned pages_free;

  ffpa_out_t   pending_replies[$];
  int unsigned held_base[$];
  int unsigned held_len[$];
  int unsigned fails;

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  function automatic int unsigned sat_sum(int unsigned a, int unsigned b);
    return (a + b > LEN_SAT) ? LEN_SAT : a + b;
  endfunction

  function automatic ffpa_out_t allocator_reply(ffpa_in_t it);
    ffpa_out_t   r;
    int unsigned s, n, c, i, j, w, pos, bs, bl;
    logic [1:0]  err;
    logic        any;
    bit          merged [TABLE_DEPTH];
    s = it.start_page;
    n = it.page_count;
    c = (n > PAGE_SPAN - s) ? PAGE_SPAN - s : n;
    r = '0;
    err = ERR_OK;
    case (it.op)
      OP_ADD: begin
        if (c == 0) err = ERR_ZERO;
        else if (ext_cnt >= TABLE_DEPTH) err = ERR_FULL;
        else begin
          ext_base[ext_cnt] = s;
          ext_len[ext_cnt] = c;
          ext_cnt++;
          pages_free = sat_sum(pages_free, c);
        end
      end
      OP_ALLOC: begin
        if (n == 0) err = ERR_ZERO;
        else if (n > pages_free) err = ERR_SHORT;
        else begin
          for (i = 0; i < ext_cnt; i++)
            if (ext_len[i] >= n) break;
          if (i >= ext_cnt) err = ERR_SHORT;
          else begin
            r.alloc_start = ext_base[i][15:0];
            if (ext_len[i] > n) begin
              ext_base[i] = (ext_base[i] + n) & 16'hFFFF;
              ext_len[i] -= n;
            end else begin
              for (j = i; j + 1 < ext_cnt; j++) begin
                ext_base[j] = ext_base[j + 1];
                ext_len[j] = ext_len[j + 1];
              end
              ext_cnt--;
            end
            pages_free -= n;
          end
        end
      end
      OP_FREE: begin
        if (c == 0) err = ERR_ZERO;
        else begin
          bs = s;
          bl = c;
          any = 1'b0;
          for (i = 0; i < ext_cnt; i++) begin
            merged[i] = 1'b0;
            if (bs + bl == ext_base[i]) begin
              bl = sat_sum(bl, ext_len[i]);
              merged[i] = 1'b1;
            end else if (ext_base[i] + ext_len[i] == bs) begin
              bl = sat_sum(ext_len[i], bl);
              bs = ext_base[i];
              merged[i] = 1'b1;
            end
            if (merged[i]) any = 1'b1;
          end
          if (!any && ext_cnt >= TABLE_DEPTH) err = ERR_FULL;
          else begin
            w = 0;
            for (i = 0; i < ext_cnt; i++)
              if (!merged[i]) begin
                ext_base[w] = ext_base[i];
                ext_len[w] = ext_len[i];
                w++;
              end
            ext_cnt = w;
            for (pos = 0; pos < ext_cnt; pos++)
              if (bs + bl <= ext_base[pos]) break;
            for (i = ext_cnt; i > pos; i--) begin
              ext_base[i] = ext_base[i - 1];
              ext_len[i] = ext_len[i - 1];
            end
            ext_base[pos] = bs & 16'hFFFF;
            ext_len[pos] = bl & LEN_SAT;
            ext_cnt++;
            pages_free = sat_sum(pages_free, c);
          end
        end
      end
      default: err = ERR_ZERO;
    endcase
    if (err != ERR_OK) r.alloc_start = '0;
    r.granted = (err == ERR_OK);
    r.free_total = pages_free[16:0];
    r.error_code = err;
    return r;
  endfunction

  // drives one request and records its expected reply once accepted
  task automatic issue_request(logic [1:0] op, int unsigned s, int unsigned n);
    int unsigned gap;
    ffpa_in_t    it;
    ffpa_out_t   r;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    it.op = op;
    it.start_page = s[15:0];
    it.page_count = n[16:0];
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    r = allocator_reply(it);
    pending_replies.push_back(r);
    if (op == OP_ALLOC && r.granted) begin
      held_base.push_back(r.alloc_start);
      held_len.push_back(n);
    end
  endtask

  always @(posedge clk) begin
    ffpa_out_t e;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected transaction, actual %p", $time, out_item);
        fails++;
      end else begin
        e = pending_replies.pop_front();
        if (out_item.granted !== e.granted) begin
          $display("%0t: granted expected %0d actual %0d", $time, e.granted, out_item.granted);
          fails++;
        end
        if (out_item.alloc_start !== e.alloc_start) begin
          $display("%0t: alloc_start expected %0d actual %0d", $time, e.alloc_start,
                   out_item.alloc_start);
          fails++;
        end
        if (out_item.free_total !== e.free_total) begin
          $display("%0t: free_total expected %0d actual %0d", $time, e.free_total,
                   out_item.free_total);
          fails++;
        end
        if (out_item.error_code !== e.error_code) begin
          $display("%0t: error_code expected %0d actual %0d", $time, e.error_code,
                   out_item.error_code);
          fails++;
        end
      end
    end
  end

  // give back one held extent, sometimes in two pieces
  task automatic release_held();
    int unsigned k, b, l, cut;
    k = $urandom_range(0, held_base.size() - 1);
    b = held_base[k];
    l = held_len[k];
    held_base.delete(k);
    held_len.delete(k);
    if (l > 1 && $urandom_range(0, 2) == 0) begin
      cut = $urandom_range(1, l - 1);
      issue_request(OP_FREE, b + cut, l - cut);
      issue_request(OP_FREE, b, cut);
    end else begin
      issue_request(OP_FREE, b, l);
    end
  endtask

  task automatic test_corner_cases();
    issue_request(OP_ALLOC, 0, 1);          // empty table
    issue_request(OP_ADD, 100, 0);          // zero count
    issue_request(OP_FREE, 100, 0);
    issue_request(OP_ALLOC, 0, 0);
    issue_request(OP_UNUSED, 16'hFFFF, 17'h1FFFF); // undefined opcode
    issue_request(OP_ADD, 16'hFFFF, 17'h1FFFF); // clipped to one page
    issue_request(OP_ADD, 0, 16);
    issue_request(OP_ADD, 32, 16);
    issue_request(OP_ALLOC, 16'hFFFF, 20);  // total ok, no extent fits
    issue_request(OP_ALLOC, 0, 4);          // shrink from the front
    issue_request(OP_ALLOC, 0, 12);         // exact fit removes the extent
    issue_request(OP_FREE, 0, 16);          // no neighbor
    issue_request(OP_FREE, 16, 16);         // merges below and above
    issue_request(OP_ALLOC, 0, 17'h1FFFF);
    issue_request(OP_ADD, 0, 65536);
    issue_request(OP_ADD, 0, 65536);        // total saturates
    issue_request(OP_FREE, 65535, 17'h1FFFF);
    issue_request(OP_ALLOC, 0, 65536);
    issue_request(OP_ALLOC, 0, 17'h10000);
    issue_request(OP_ALLOC, 0, 1);
    // the saturated total can fall below what the table still holds
    while (ext_cnt > 0 && ext_len[0] <= pages_free)
      issue_request(OP_ALLOC, 0, ext_len[0]);
    held_base.delete();
    held_len.delete();
  endtask

  task automatic test_table_full();
    int unsigned p;
    p = 1000;
    while (ext_cnt < TABLE_DEPTH) begin
      issue_request(OP_ADD, p, 1);
      p += 2;
    end
    issue_request(OP_ADD, 60000, 5);        // table full on add
    issue_request(OP_FREE, 60000, 5);       // full, nothing to merge
    issue_request(OP_FREE, 1001, 1);        // merge frees a slot
    issue_request(OP_FREE, 3, 1);
    while (ext_cnt > 4 && ext_len[0] <= pages_free)
      issue_request(OP_ALLOC, 0, ext_len[0]);
  endtask

  task automatic test_random_traffic();
    int unsigned k, sel, n;
    for (k = 0; k < 540; k++) begin
      sel = $urandom_range(0, 99);
      if (ext_cnt > 40 && sel < 60) begin
        issue_request(OP_ALLOC, $urandom, ext_len[$urandom_range(0, ext_cnt - 1)]);
      end else if (sel < 25) begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 17'h1FFFF)
                                          : $urandom_range(0, 300);
        issue_request(OP_ADD, $urandom_range(0, 65535), n);
      end else if (sel < 60) begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 17'h1FFFF)
                                          : $urandom_range(0, 200);
        issue_request(OP_ALLOC, $urandom_range(0, 65535), n);
      end else if (sel < 90 && held_base.size() > 0) begin
        release_held();
      end else if (sel < 96) begin
        issue_request(OP_FREE, $urandom_range(0, 65535), $urandom_range(0, 17'h1FFFF));
      end else begin
        issue_request(OP_UNUSED, $urandom_range(0, 65535), $urandom_range(0, 17'h1FFFF));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    fails = 0;
    ext_cnt = 0;
    pages_free = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_corner_cases();
    test_table_full();
    test_random_traffic();
    @(negedge clk);
    start <= 1'b0;
    while (pending_replies.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
